// File: design/ill_pkg.sv
// Shared types, token codes and keyword table for the instruction list lexer.
// No dependencies.
package ill_pkg;

    localparam int KW_MAX   = 18;
    localparam int OFF_W    = 24;
    localparam int LN_W     = 16;
    localparam int KW_COUNT = 47;
    localparam int LEN_W    = 5;
    localparam int NSLOT    = 5;

    localparam logic [5:0] T_BOOLLIT = 6'd45;
    localparam logic [5:0] T_IDENT   = 6'd46;
    localparam logic [5:0] T_LABEL   = 6'd47;
    localparam logic [5:0] T_INT     = 6'd48;
    localparam logic [5:0] T_REAL    = 6'd49;
    localparam logic [5:0] T_STRING  = 6'd50;
    localparam logic [5:0] T_ASSIGN  = 6'd51;
    localparam logic [5:0] T_COLON   = 6'd52;
    localparam logic [5:0] T_SEMI    = 6'd53;
    localparam logic [5:0] T_COMMA   = 6'd54;
    localparam logic [5:0] T_LPAREN  = 6'd55;
    localparam logic [5:0] T_RPAREN  = 6'd56;
    localparam logic [5:0] T_UNKNOWN = 6'd57;
    localparam logic [5:0] T_EOF     = 6'd58;

    typedef enum logic [10:0] {
        M_IDLE     = 11'b00000000001,
        M_WORD     = 11'b00000000010,
        M_WCOLON   = 11'b00000000100,
        M_NUM      = 11'b00000001000,
        M_MINUS    = 11'b00000010000,
        M_LPAREN   = 11'b00000100000,
        M_SLASH    = 11'b00001000000,
        M_COLON    = 11'b00010000000,
        M_STRING   = 11'b00100000000,
        M_BCOMMENT = 11'b01000000000,
        M_LCOMMENT = 11'b10000000000
    } t_mode;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [5:0]       token_type;
        logic [OFF_W-1:0] text_start;
        logic [OFF_W-1:0] text_end;
        logic [LN_W-1:0]  start_line;
        logic [LN_W-1:0]  start_col;
        logic             bool_value;
    } t_tok;

    typedef struct packed {
        logic [5:0]       token_type;
        logic [OFF_W-1:0] text_start;
        logic [OFF_W-1:0] text_end;
        logic [LN_W-1:0]  start_line;
        logic [LN_W-1:0]  start_col;
        logic             bool_value;
        logic             last_result;
    } t_out;

    // all records one byte can cause, in emission order
    typedef struct packed {
        logic [NSLOT-1:0]       mask;
        t_tok [NSLOT-1:0]       rec;
    } t_bundle;

    typedef struct packed {
        logic [5:0] code;
        logic       bv;
    } t_kw;

    localparam logic [8*KW_MAX-1:0] KW_TXT [KW_COUNT] = '{
        "LD", "LDN", "ST", "STN", "ADD", "SUB", "MUL", "DIV", "MOD", "AND",
        "ANDN", "OR", "ORN", "XOR", "XORN", "NOT", "GT", "GE", "LT", "LE",
        "EQ", "NE", "JMP", "JMPC", "JMPCN", "CAL", "CALC", "CALCN", "RET",
        "PROGRAM", {"END_", "PROGRAM"}, "FUNCTION", {"END_", "FUNCTION"},
        {"FUNCTION", "_BLOCK"}, {"END_", "FUNCTION", "_BLOCK"}, "VAR",
        {"VAR", "_INPUT"}, {"VAR", "_OUTPUT"}, {"VAR", "_IN_OUT"},
        "END_VAR", "BOOL", "INT", "DINT", "REAL", "TIME", "TRUE", "FALSE"
    };

    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        5'd2, 5'd3, 5'd2, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3,
        5'd4, 5'd2, 5'd3, 5'd3, 5'd4, 5'd3, 5'd2, 5'd2, 5'd2, 5'd2,
        5'd2, 5'd2, 5'd3, 5'd4, 5'd5, 5'd3, 5'd4, 5'd5, 5'd3,
        5'd7, 5'd11, 5'd8, 5'd12, 5'd14,
        5'd18, 5'd3, 5'd9, 5'd10, 5'd10,
        5'd7, 5'd4, 5'd3, 5'd4, 5'd4, 5'd4, 5'd4, 5'd5
    };

    // text is right-justified in KW_TXT; byte j of the word sits in wbuf[8*j +: 8]
    function automatic t_kw kw_lookup(input logic [8*KW_MAX-1:0] wbuf,
                                      input logic [LEN_W-1:0] len);
        t_kw  res;
        logic hit;
        logic eq;
        int   n;
        res = '{code: T_IDENT, bv: 1'b0};
        hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            n  = int'(KW_LEN[i]);
            eq = (len == KW_LEN[i]);
            for (int j = 0; j < KW_MAX; j++) begin
                if (j < n) begin
                    eq = eq && (wbuf[8*j +: 8] == KW_TXT[i][8*(n-1-j) +: 8]);
                end
            end
            if (eq && !hit) begin
                hit      = 1'b1;
                res.code = (i >= KW_COUNT - 2) ? T_BOOLLIT : 6'(i);
                res.bv   = (i == KW_COUNT - 2);
            end
        end
        return res;
    endfunction

endpackage

// File: design/ill_front.sv
// Front end: takes one source byte a beat, runs the lexer state and builds
// the bundle of token records that byte completes. Depends on ill_pkg.
module ill_front import ill_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in     i_in,
    output logic    o_push,
    output t_bundle o_bundle,
    input  logic    i_full
);

    t_mode             r_mode, n_mode;
    logic [OFF_W-1:0]  r_tok_off, n_tok_off, r_cur_off, n_cur_off, r_pend_off, n_pend_off;
    logic [LN_W-1:0]   r_tok_line, n_tok_line, r_tok_col, n_tok_col;
    logic [LN_W-1:0]   r_cur_line, n_cur_line, r_cur_col, n_cur_col;
    logic [LN_W-1:0]   r_pend_line, n_pend_line, r_pend_col, n_pend_col;
    logic [8*KW_MAX-1:0] r_wbuf, n_wbuf;
    logic [LEN_W-1:0]  r_wlen, n_wlen;
    logic              r_seen_dot, n_seen_dot, r_cstar, n_cstar;

    logic [7:0]        b;
    logic [OFF_W-1:0]  nxt;
    logic              redo, accept, word_ch, digit, space;
    t_kw               kw_now, kw_flush;
    t_bundle           bnd;

    function automatic t_tok mk(input logic [5:0] ty, input logic [OFF_W-1:0] s,
                                input logic [OFF_W-1:0] e, input logic [LN_W-1:0] l,
                                input logic [LN_W-1:0] c, input logic bv);
        t_tok t;
        t = '{token_type: ty, text_start: s, text_end: e, start_line: l,
              start_col: c, bool_value: bv};
        return t;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_in.src_byte;
    assign nxt     = (&r_cur_off) ? r_cur_off : r_cur_off + 1'b1;
    assign digit   = (b >= "0") && (b <= "9");
    assign word_ch = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"))
                     || (b == "_") || digit;
    assign space   = (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    assign kw_now  = kw_lookup(r_wbuf, r_wlen);

    always_comb begin
        n_mode = r_mode;
        n_tok_off = r_tok_off; n_tok_line = r_tok_line; n_tok_col = r_tok_col;
        n_pend_off = r_pend_off; n_pend_line = r_pend_line; n_pend_col = r_pend_col;
        n_wbuf = r_wbuf; n_wlen = r_wlen;
        n_seen_dot = r_seen_dot; n_cstar = r_cstar;
        redo = 1'b0;
        bnd  = '0;
        kw_flush = '{code: T_IDENT, bv: 1'b0};

        unique case (r_mode)
            M_IDLE: redo = 1'b1;
            M_WORD: begin
                if (word_ch) begin
                    if (r_wlen < LEN_W'(KW_MAX)) n_wbuf[8*r_wlen +: 8] = b;
                    if (r_wlen <= LEN_W'(KW_MAX)) n_wlen = r_wlen + 1'b1;
                end else if (b == ":") begin
                    n_mode = M_WCOLON;
                    n_pend_off = r_cur_off; n_pend_line = r_cur_line; n_pend_col = r_cur_col;
                end else begin
                    bnd.mask[0] = 1'b1;
                    bnd.rec[0]  = mk(kw_now.code, r_tok_off, r_cur_off, r_tok_line,
                                     r_tok_col, kw_now.bv);
                    redo = 1'b1;
                end
            end
            M_WCOLON: begin
                if (b == "=") begin
                    bnd.mask[1:0] = 2'b11;
                    bnd.rec[0] = mk(kw_now.code, r_tok_off, r_pend_off, r_tok_line,
                                    r_tok_col, kw_now.bv);
                    bnd.rec[1] = mk(T_ASSIGN, r_pend_off, nxt, r_pend_line, r_pend_col, 1'b0);
                    n_mode = M_IDLE;
                end else begin
                    bnd.mask[0] = 1'b1;
                    bnd.rec[0]  = mk(T_LABEL, r_tok_off, r_pend_off, r_tok_line,
                                     r_tok_col, 1'b0);
                    redo = 1'b1;
                end
            end
            M_NUM: begin
                if (digit) begin
                end else if (b == "." && !r_seen_dot) begin
                    n_seen_dot = 1'b1;
                end else begin
                    bnd.mask[0] = 1'b1;
                    bnd.rec[0]  = mk(r_seen_dot ? T_REAL : T_INT, r_tok_off, r_cur_off,
                                     r_tok_line, r_tok_col, 1'b0);
                    redo = 1'b1;
                end
            end
            M_MINUS, M_SLASH: begin
                if (r_mode == M_MINUS && digit) begin
                    n_mode = M_NUM; n_seen_dot = 1'b0;
                end else if (r_mode == M_SLASH && b == "/") begin
                    n_mode = M_LCOMMENT;
                end else begin
                    bnd.mask[0] = 1'b1;
                    bnd.rec[0]  = mk(T_UNKNOWN, r_tok_off, r_cur_off, r_tok_line,
                                     r_tok_col, 1'b0);
                    redo = 1'b1;
                end
            end
            M_LPAREN: begin
                if (b == "*") begin
                    n_mode = M_BCOMMENT; n_cstar = 1'b0;
                end else begin
                    bnd.mask[0] = 1'b1;
                    bnd.rec[0]  = mk(T_LPAREN, r_tok_off, r_cur_off, r_tok_line,
                                     r_tok_col, 1'b0);
                    redo = 1'b1;
                end
            end
            M_COLON: begin
                bnd.mask[0] = 1'b1;
                if (b == "=") begin
                    bnd.rec[0] = mk(T_ASSIGN, r_tok_off, nxt, r_tok_line, r_tok_col, 1'b0);
                    n_mode = M_IDLE;
                end else begin
                    bnd.rec[0] = mk(T_COLON, r_tok_off, r_cur_off, r_tok_line,
                                    r_tok_col, 1'b0);
                    redo = 1'b1;
                end
            end
            M_STRING: begin
                if (b == "'") begin
                    bnd.mask[0] = 1'b1;
                    bnd.rec[0]  = mk(T_STRING, r_tok_off, r_cur_off, r_tok_line,
                                     r_tok_col, 1'b0);
                    n_mode = M_IDLE;
                end
            end
            M_BCOMMENT: begin
                if (r_cstar && b == ")") begin
                    n_mode = M_IDLE; n_cstar = 1'b0;
                end else begin
                    n_cstar = (b == "*");
                end
            end
            M_LCOMMENT: if (b == 8'h0a) n_mode = M_IDLE;
            default: redo = 1'b1;
        endcase

        if (redo) begin
            n_mode = M_IDLE;
            if (!space) begin
                n_tok_off = r_cur_off; n_tok_line = r_cur_line; n_tok_col = r_cur_col;
                priority if (b == "(") n_mode = M_LPAREN;
                else if (b == "/") n_mode = M_SLASH;
                else if (b == "-") n_mode = M_MINUS;
                else if (b == ":") n_mode = M_COLON;
                else if (digit) begin
                    n_mode = M_NUM; n_seen_dot = 1'b0;
                end else if (b == "'") begin
                    n_mode = M_STRING; n_tok_off = nxt;
                end else if (word_ch) begin
                    n_mode = M_WORD; n_wbuf[7:0] = b; n_wlen = LEN_W'(1);
                end else begin
                    bnd.mask[2] = 1'b1;
                    bnd.rec[2]  = mk((b == ";") ? T_SEMI : (b == ",") ? T_COMMA :
                                     (b == ")") ? T_RPAREN : T_UNKNOWN,
                                     r_cur_off, nxt, r_cur_line, r_cur_col, 1'b0);
                end
            end
        end

        n_cur_off = nxt;
        if (b == 8'h0a) begin
            n_cur_line = (&r_cur_line) ? r_cur_line : r_cur_line + 1'b1;
            n_cur_col  = LN_W'(1);
        end else begin
            n_cur_line = r_cur_line;
            n_cur_col  = (&r_cur_col) ? r_cur_col : r_cur_col + 1'b1;
        end

        if (i_in.last_byte) begin
            // flush whatever is pending, then close with end of file
            kw_flush = kw_lookup(n_wbuf, n_wlen);
            bnd.mask[3] = 1'b1;
            unique case (n_mode)
                M_WORD:   bnd.rec[3] = mk(kw_flush.code, n_tok_off, nxt, n_tok_line,
                                          n_tok_col, kw_flush.bv);
                M_WCOLON: bnd.rec[3] = mk(T_LABEL, n_tok_off, n_pend_off, n_tok_line,
                                          n_tok_col, 1'b0);
                M_NUM:    bnd.rec[3] = mk(n_seen_dot ? T_REAL : T_INT, n_tok_off, nxt,
                                          n_tok_line, n_tok_col, 1'b0);
                M_MINUS, M_SLASH:
                          bnd.rec[3] = mk(T_UNKNOWN, n_tok_off, nxt, n_tok_line,
                                          n_tok_col, 1'b0);
                M_LPAREN: bnd.rec[3] = mk(T_LPAREN, n_tok_off, nxt, n_tok_line,
                                          n_tok_col, 1'b0);
                M_COLON:  bnd.rec[3] = mk(T_COLON, n_tok_off, nxt, n_tok_line,
                                          n_tok_col, 1'b0);
                M_STRING: bnd.rec[3] = mk(T_STRING, n_tok_off, nxt, n_tok_line,
                                          n_tok_col, 1'b0);
                default:  bnd.mask[3] = 1'b0;
            endcase
            bnd.mask[4] = 1'b1;
            bnd.rec[4]  = mk(T_EOF, nxt, nxt, n_cur_line, n_cur_col, 1'b0);
            n_mode = M_IDLE;
            n_tok_off = '0; n_tok_line = LN_W'(1); n_tok_col = LN_W'(1);
            n_cur_off = '0; n_cur_line = LN_W'(1); n_cur_col = LN_W'(1);
            n_wlen = '0; n_seen_dot = 1'b0; n_cstar = 1'b0;
            n_pend_off = '0; n_pend_line = '0; n_pend_col = '0;
        end
    end

    assign o_push   = accept && (|bnd.mask);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_tok_off <= '0; r_tok_line <= LN_W'(1); r_tok_col <= LN_W'(1);
            r_cur_off <= '0; r_cur_line <= LN_W'(1); r_cur_col <= LN_W'(1);
            r_pend_off <= '0; r_pend_line <= '0; r_pend_col <= '0;
            r_wlen <= '0; r_seen_dot <= 1'b0; r_cstar <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_tok_off <= n_tok_off; r_tok_line <= n_tok_line; r_tok_col <= n_tok_col;
            r_cur_off <= n_cur_off; r_cur_line <= n_cur_line; r_cur_col <= n_cur_col;
            r_pend_off <= n_pend_off; r_pend_line <= n_pend_line; r_pend_col <= n_pend_col;
            r_wlen <= n_wlen; r_seen_dot <= n_seen_dot; r_cstar <= n_cstar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_wbuf <= n_wbuf;
    end

endmodule

// File: design/ill_queue.sv
// Two-entry queue of token bundles between front and back end.
// Depends on ill_pkg.
module ill_queue import ill_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_bundle o_data
);

    t_bundle    r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = |r_cnt;
    assign o_data  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_data;
    end

endmodule

// File: design/ill_back.sv
// Back end: walks the records of one bundle and hands them out one beat at a
// time through an output register. Depends on ill_pkg.
module ill_back import ill_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_bundle i_q_data,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_out    o_out
);

    logic [NSLOT-1:0] r_mask, pick, rest;
    t_tok [NSLOT-1:0] r_rec;
    t_tok             sel;
    logic             r_ov, load;
    t_out             r_out;

    assign load = !r_ov || i_ready;
    assign pick = r_mask & (~r_mask + 1'b1);
    assign rest = load ? (r_mask & ~pick) : r_mask;
    assign o_q_pop = i_q_valid && (rest == '0);

    always_comb begin
        sel = r_rec[0];
        for (int k = NSLOT - 1; k >= 0; k--) begin
            if (pick[k]) sel = r_rec[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_mask <= '0;
        end else begin
            if (load) r_ov <= |r_mask;
            r_mask <= o_q_pop ? i_q_data.mask : rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_rec <= i_q_data.rec;
        if (load && (|r_mask)) begin
            r_out <= '{token_type: sel.token_type, text_start: sel.text_start,
                       text_end: sel.text_end, start_line: sel.start_line,
                       start_col: sel.start_col, bool_value: sel.bool_value,
                       last_result: (r_mask & ~pick) == '0};
        end
    end

    assign o_valid = r_ov;
    assign o_out   = r_out;

endmodule

// File: design/instruction_list_lexer.sv
// Instruction list lexer: one source byte per beat in, one token record per
// beat out; built from ill_front, ill_queue and ill_back (ill_pkg types).
//
// A byte is taken every cycle as long as the two-entry bundle queue has room.
// Bytes that complete at most one token therefore stream at one byte per
// cycle while the output is ready. A byte that completes two or three tokens
// (word then := or punctuation, or the last byte with its flush and end of
// file) holds the output port until all of them are out; bytes that complete
// nothing (the rest of a word, number or comment) let the queue catch up,
// otherwise the input stalls once the queue is full. A token passes through
// the queue entry, the back end's record register and its output register.
module instruction_list_lexer import ill_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic    q_push, q_full, q_pop, q_valid;
    t_bundle q_in, q_out;

    ill_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_in(i_in),
        .o_push(q_push), .o_bundle(q_in), .i_full(q_full)
    );

    ill_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_data(q_out)
    );

    ill_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_data(q_out), .o_q_pop(q_pop),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_out(o_out)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full)) else $error("bundle queue overflow");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.token_type == T_EOF) |-> o_out.last_result)
        else $error("end of file not last record of its beat");
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.text_end >= o_out.text_start))
        else $error("token text ends before it starts");
`endif

endmodule

// File: tb/sv/instruction_list_lexer_test.sv
// Self-checking bench for the instruction list lexer: streams source bytes,
// predicts every token record and compares beat by beat. Depends on ill_pkg.
module instruction_list_lexer_test;
    import ill_pkg::*;

    localparam int OFF_MAX    = (1 << OFF_W) - 1;
    localparam int LN_MAX     = (1 << LN_W) - 1;
    localparam int LIMIT      = 400000;
    localparam int KW_LONGEST = 34;

    typedef enum int {
        S_IDLE, S_WORD, S_WCOLON, S_NUM, S_MINUS, S_LPAREN, S_SLASH, S_COLON,
        S_STRING, S_BCOMMENT, S_LCOMMENT
    } t_lexstate;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    instruction_list_lexer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_in(i_in), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // lexer shadow state
    t_lexstate  lx_state;
    int         tok_off, tok_line, tok_col;
    int         cur_off, cur_line, cur_col;
    logic [7:0] word_chars [KW_MAX];
    int         word_len;
    bit         got_dot, got_star;
    int         colon_off, colon_line, colon_col;

    t_in  byte_q [$];
    t_out token_q [$];
    t_out step_toks [$];

    int  errors = 0;
    int  cycles = 0;
    int  bytes_sent = 0;
    int  toks_seen = 0;
    int  in_idle = 14;
    int  out_idle = 66;

    function automatic int sat(int v, int mx);
        return (v >= mx) ? mx : v + 1;
    endfunction

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alp(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit is_ws(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // keyword text as a string, first character first
    function automatic string kw_text(int i);
        string w;
        int    n;
        w = "";
        n = int'(KW_LEN[i]);
        for (int j = 0; j < n; j++) w = {w, string'(KW_TXT[i][8*(n-1-j) +: 8])};
        return w;
    endfunction

    task automatic add_tok(logic [5:0] ty, int s, int e, int ln, int cl, bit bv);
        t_out t;
        if (step_toks.size() >= 3) return;
        t = '0;
        t.token_type = ty;
        t.text_start = s[OFF_W-1:0];
        t.text_end   = e[OFF_W-1:0];
        t.start_line = ln[LN_W-1:0];
        t.start_col  = cl[LN_W-1:0];
        t.bool_value = bv;
        step_toks.insert(step_toks.size(), t);
    endtask

    task automatic add_at_start(logic [5:0] ty, int e);
        add_tok(ty, tok_off, e, tok_line, tok_col, 1'b0);
    endtask

    // keyword classification straight from the table text
    task automatic add_word(int e);
        logic [5:0] code;
        bit         bv;
        bit         eq;
        int         n;
        code = T_IDENT;
        bv = 1'b0;
        if (word_len <= KW_MAX) begin
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                n = int'(KW_LEN[i]);
                eq = (n == word_len);
                for (int j = 0; j < KW_MAX; j++)
                    if (eq && j < n && word_chars[j] != KW_TXT[i][8*(n-1-j) +: 8])
                        eq = 1'b0;
                if (eq) begin
                    code = (i >= KW_COUNT - 2) ? T_BOOLLIT : 6'(i);
                    bv = (i == KW_COUNT - 2);
                end
            end
        end
        add_tok(code, tok_off, e, tok_line, tok_col, bv);
    endtask

    task automatic lex_reset();
        lx_state = S_IDLE;
        tok_off = 0; tok_line = 1; tok_col = 1;
        cur_off = 0; cur_line = 1; cur_col = 1;
        for (int i = 0; i < KW_MAX; i++) word_chars[i] = 8'h00;
        word_len = 0; got_dot = 0; got_star = 0;
        colon_off = 0; colon_line = 0; colon_col = 0;
    endtask

    task automatic start_token(logic [7:0] b, int off, int ln, int cl, int nx);
        lx_state = S_IDLE;
        if (is_ws(b)) return;
        tok_off = off; tok_line = ln; tok_col = cl;
        if (b == "(") lx_state = S_LPAREN;
        else if (b == "/") lx_state = S_SLASH;
        else if (b == "-") lx_state = S_MINUS;
        else if (b == ":") lx_state = S_COLON;
        else if (is_dig(b)) begin
            lx_state = S_NUM; got_dot = 0;
        end else if (b == 8'h27) begin
            lx_state = S_STRING; tok_off = nx;
        end else if (is_alp(b) || b == "_") begin
            lx_state = S_WORD; word_chars[0] = b; word_len = 1;
        end else if (b == ";") add_at_start(T_SEMI, nx);
        else if (b == ",") add_at_start(T_COMMA, nx);
        else if (b == ")") add_at_start(T_RPAREN, nx);
        else add_at_start(T_UNKNOWN, nx);
    endtask

    task automatic lex_byte(t_in it);
        logic [7:0] b;
        int off, ln, cl, nx;
        bit redo;
        b = it.src_byte;
        off = cur_off; ln = cur_line; cl = cur_col;
        nx = sat(off, OFF_MAX);
        redo = 0;
        step_toks.delete();
        case (lx_state)
            S_IDLE: redo = 1;
            S_WORD: begin
                if (is_alp(b) || is_dig(b) || b == "_") begin
                    if (word_len < KW_MAX) word_chars[word_len] = b;
                    if (word_len <= KW_MAX) word_len++;
                end else if (b == ":") begin
                    lx_state = S_WCOLON;
                    colon_off = off; colon_line = ln; colon_col = cl;
                end else begin
                    add_word(off); redo = 1;
                end
            end
            S_WCOLON: begin
                if (b == "=") begin
                    add_word(colon_off);
                    add_tok(T_ASSIGN, colon_off, nx, colon_line, colon_col, 1'b0);
                    lx_state = S_IDLE;
                end else begin
                    add_at_start(T_LABEL, colon_off); redo = 1;
                end
            end
            S_NUM: begin
                if (is_dig(b)) ;
                else if (b == "." && !got_dot) got_dot = 1;
                else begin
                    add_at_start(got_dot ? T_REAL : T_INT, off); redo = 1;
                end
            end
            S_MINUS: begin
                if (is_dig(b)) begin
                    lx_state = S_NUM; got_dot = 0;
                end else begin
                    add_at_start(T_UNKNOWN, off); redo = 1;
                end
            end
            S_LPAREN: begin
                if (b == "*") begin
                    lx_state = S_BCOMMENT; got_star = 0;
                end else begin
                    add_at_start(T_LPAREN, off); redo = 1;
                end
            end
            S_SLASH: begin
                if (b == "/") lx_state = S_LCOMMENT;
                else begin
                    add_at_start(T_UNKNOWN, off); redo = 1;
                end
            end
            S_COLON: begin
                if (b == "=") begin
                    add_at_start(T_ASSIGN, nx); lx_state = S_IDLE;
                end else begin
                    add_at_start(T_COLON, off); redo = 1;
                end
            end
            S_STRING: begin
                if (b == 8'h27) begin
                    add_at_start(T_STRING, off); lx_state = S_IDLE;
                end
            end
            S_BCOMMENT: begin
                if (got_star && b == ")") begin
                    lx_state = S_IDLE; got_star = 0;
                end else got_star = (b == "*");
            end
            S_LCOMMENT: if (b == 8'h0a) lx_state = S_IDLE;
            default: redo = 1;
        endcase
        if (redo) start_token(b, off, ln, cl, nx);
        cur_off = nx;
        if (b == 8'h0a) begin
            cur_line = sat(ln, LN_MAX); cur_col = 1;
        end else cur_col = sat(cl, LN_MAX);
        if (it.last_byte) begin
            case (lx_state)
                S_WORD:   add_word(cur_off);
                S_WCOLON: add_at_start(T_LABEL, colon_off);
                S_NUM:    add_at_start(got_dot ? T_REAL : T_INT, cur_off);
                S_MINUS, S_SLASH: add_at_start(T_UNKNOWN, cur_off);
                S_LPAREN: add_at_start(T_LPAREN, cur_off);
                S_COLON:  add_at_start(T_COLON, cur_off);
                S_STRING: add_at_start(T_STRING, cur_off);
                default: ;
            endcase
            add_tok(T_EOF, cur_off, cur_off, cur_line, cur_col, 1'b0);
            lex_reset();
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_result = 1'b1;
        foreach (step_toks[i]) token_q.insert(token_q.size(), step_toks[i]);
    endtask

    task automatic push_text(string s, bit end_it);
        t_in it;
        for (int i = 0; i < s.len(); i++) begin
            it.src_byte = s[i];
            it.last_byte = end_it && (i == s.len() - 1);
            byte_q.insert(byte_q.size(), it);
        end
    endtask

    function automatic string rand_fragment();
        string w;
        int    k;
        case ($urandom_range(0, 13))
            0: w = kw_text($urandom_range(0, KW_COUNT-1));
            1: begin
                w = "";
                k = $urandom_range(1, 24);
                for (int i = 0; i < k; i++) w = {w, string'(8'($urandom_range(97, 122)))};
            end
            2: w = $sformatf("%0d", $urandom_range(0, 99999));
            3: w = $sformatf("-%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
            4: w = "'txt ok'";
            5: w = "(* note **) ";
            6: w = "// line\n";
            7: w = "lbl: ";
            8: w = "x:=";
            9: w = " ;, ()\t\n";
            10: w = "- / : (";
            11: w = {"_", kw_text($urandom_range(0, KW_COUNT-1))};
            12: w = string'(8'($urandom_range(0, 255)));
            default: w = " ";
        endcase
        return w;
    endfunction

    // driver: hold the beat until accepted, then advance
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (i_in_valid) lex_byte(i_in);
                if (byte_q.size() > 0 && $urandom_range(0, 99) >= in_idle) begin
                    i_in <= byte_q.pop_front();
                    i_in_valid <= 1'b1;
                    bytes_sent <= bytes_sent + 1;
                end else i_in_valid <= 1'b0;
            end
            i_out_ready <= ($urandom_range(0, 99) >= out_idle);
        end
    end

    // monitor: compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            toks_seen <= toks_seen + 1;
            if (token_q.size() == 0) begin
                if (errors < 10) $display("unexpected token %p", o_out);
                errors <= errors + 1;
            end else begin
                if (o_out !== token_q[0]) begin
                    if (errors < 10)
                        $display("mismatch: expected %p got %p", token_q[0], o_out);
                    errors <= errors + 1;
                end
                void'(token_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("[instruction_list_lexer] ERROR");
            $finish;
        end
    end

    initial begin
        t_in it;
        lex_reset();
        // directed: boundaries and the awkward lookaheads
        push_text({kw_text(KW_LONGEST), "X ABCDEFGHIJKLMNOPQRSTU "}, 0);
        push_text("a:=1;b: -x /y (z) -3.25 1.2.3 'q' (*)*) // c\n", 0);
        push_text(":= : , ", 0);
        it.src_byte = 8'hff; it.last_byte = 0; byte_q.insert(byte_q.size(), it);
        it.src_byte = 8'h00; byte_q.insert(byte_q.size(), it);
        push_text("w:", 1);
        push_text("'open", 1);
        push_text("(* open", 1);
        push_text("-", 1);
        push_text("x", 1);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < 3; n++) begin
            string s;
            if (n == 1) begin
                in_idle = 66; out_idle = 14;
            end else if (n == 2) begin
                in_idle = 0; out_idle = 0;
            end
            // a third of the keyword table each phase, then a short random source
            for (int i = n; i < KW_COUNT; i += 3) push_text({kw_text(i), " "}, 0);
            s = "";
            repeat ($urandom_range(1, 3)) s = {s, rand_fragment()};
            push_text(s, 1);
            while (byte_q.size() != 0 || i_in_valid || token_q.size() != 0)
                @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        $display("sent %0d source bytes, checked %0d token beats", bytes_sent, toks_seen);
        if (errors == 0 && token_q.size() == 0)
            $display("[instruction_list_lexer] OK");
        else
            $display("[instruction_list_lexer] ERROR");
        $finish;
    end
endmodule

// File: files.f
design/ill_pkg.sv
design/ill_front.sv
design/ill_queue.sv
design/ill_back.sv
design/instruction_list_lexer.sv
tb/sv/instruction_list_lexer_test.sv
